[design/velocity_command_smoother_unit_macros.svh]
// Assertion macros for the velocity command smoother.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef VELOCITY_COMMAND_SMOOTHER_UNIT_MACROS_SVH
`define VELOCITY_COMMAND_SMOOTHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/vcs_pkg.sv]
package vcs_pkg;

    // Default parameter values.
    localparam int DEF_PHASE_STEPS = 5;
    localparam int DEF_VALUE_WIDTH = 16;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // Operation selector carried in tuser.
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_LIN_MAX_STEP = 3'd0;
    localparam logic [2:0] REG_ANG_MAX_STEP = 3'd1;
    localparam logic [2:0] REG_LIN_FLOOR    = 3'd2;
    localparam logic [2:0] REG_LIN_CEILING  = 3'd3;
    localparam logic [2:0] REG_ANG_BOUND    = 3'd4;

    // Register reset values.
    localparam int RST_LIN_MAX_STEP = 164;
    localparam int RST_ANG_MAX_STEP = 82;
    localparam int RST_LIN_FLOOR    = 0;
    localparam int RST_LIN_CEILING  = 3277;
    localparam int RST_ANG_BOUND    = 2048;

    // Number of samples held in the history.
    typedef logic [1:0] t_hist_cnt;
    localparam t_hist_cnt HIST_FULL = 2'd3;

    // Per-word control handed from the top level to each lane.
    typedef struct packed {
        logic      cmd;    // a command word is accepted
        logic      tick;   // a tick word is accepted and the history is not empty
        logic      clear;  // the command is zero on both axes
        t_hist_cnt count;  // history count before the push, after any clear
    } t_lane_ctl;

endpackage

[design/vcs_cfg.sv]
module vcs_cfg #(
    parameter int VALUE_WIDTH = vcs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vcs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [vcs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [vcs_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [VALUE_WIDTH-2:0]            o_lin_max_step,
    output logic [VALUE_WIDTH-2:0]            o_ang_max_step,
    output logic signed [VALUE_WIDTH-1:0]     o_lin_floor,
    output logic signed [VALUE_WIDTH-1:0]     o_lin_ceiling,
    output logic [VALUE_WIDTH-2:0]            o_ang_bound
);

    localparam int VW  = VALUE_WIDTH;
    localparam int MSW = VALUE_WIDTH - 1;

    logic [MSW-1:0] r_lin_max_step;
    logic [MSW-1:0] r_ang_max_step;
    logic [VW-1:0]  r_lin_floor;
    logic [VW-1:0]  r_lin_ceiling;
    logic [MSW-1:0] r_ang_bound;
    logic [2:0]     reg_index;
    logic           wr_en;

    assign reg_index = paddr[vcs_pkg::CFG_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes complete in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_max_step <= MSW'(vcs_pkg::RST_LIN_MAX_STEP);
            r_ang_max_step <= MSW'(vcs_pkg::RST_ANG_MAX_STEP);
            r_lin_floor    <= VW'(vcs_pkg::RST_LIN_FLOOR);
            r_lin_ceiling  <= VW'(vcs_pkg::RST_LIN_CEILING);
            r_ang_bound    <= MSW'(vcs_pkg::RST_ANG_BOUND);
        end else if (wr_en) begin
            unique case (reg_index)
                vcs_pkg::REG_LIN_MAX_STEP: r_lin_max_step <= pwdata[MSW-1:0];
                vcs_pkg::REG_ANG_MAX_STEP: r_ang_max_step <= pwdata[MSW-1:0];
                vcs_pkg::REG_LIN_FLOOR:    r_lin_floor    <= pwdata[VW-1:0];
                vcs_pkg::REG_LIN_CEILING:  r_lin_ceiling  <= pwdata[VW-1:0];
                vcs_pkg::REG_ANG_BOUND:    r_ang_bound    <= pwdata[MSW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data returns the raw register bits.
    always_comb begin
        unique case (reg_index)
            vcs_pkg::REG_LIN_MAX_STEP: prdata = vcs_pkg::CFG_DATA_W'(r_lin_max_step);
            vcs_pkg::REG_ANG_MAX_STEP: prdata = vcs_pkg::CFG_DATA_W'(r_ang_max_step);
            vcs_pkg::REG_LIN_FLOOR:    prdata = vcs_pkg::CFG_DATA_W'(r_lin_floor);
            vcs_pkg::REG_LIN_CEILING:  prdata = vcs_pkg::CFG_DATA_W'(r_lin_ceiling);
            vcs_pkg::REG_ANG_BOUND:    prdata = vcs_pkg::CFG_DATA_W'(r_ang_bound);
            default:                   prdata = '0;
        endcase
    end

    assign o_lin_max_step = r_lin_max_step;
    assign o_ang_max_step = r_ang_max_step;
    assign o_lin_floor    = r_lin_floor;
    assign o_lin_ceiling  = r_lin_ceiling;
    assign o_ang_bound    = r_ang_bound;

endmodule

[design/vcs_lane.sv]
module vcs_lane #(
    parameter int PHASE_STEPS = vcs_pkg::DEF_PHASE_STEPS,
    parameter int VALUE_WIDTH = vcs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vcs_pkg::t_lane_ctl            i_ctl,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic [VALUE_WIDTH-2:0]        i_max_step,
    input  logic signed [VALUE_WIDTH-1:0] i_lo,
    input  logic signed [VALUE_WIDTH-1:0] i_hi,
    output logic signed [VALUE_WIDTH-1:0] o_vel_next
);

    localparam int VW = VALUE_WIDTH;
    localparam int MW = VALUE_WIDTH + 1;       // difference and sum width
    localparam int PW = VALUE_WIDTH + 3;       // prediction width before saturation
    // Reciprocal of the phase count, exact for every magnitude below 2**MW.
    localparam int SH = MW + $clog2(PHASE_STEPS);
    localparam int RW = MW + 1;
    localparam int XW = SH + MW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(PHASE_STEPS) - 64'd1) / 64'(PHASE_STEPS));

    // History, difference, step and velocity state.
    logic signed [VW-1:0] r_hist [3];
    logic signed [VW-1:0] n_hist [3];
    logic                 r_pend;
    logic [MW-1:0]        r_mag;
    logic                 r_neg;
    logic signed [VW-1:0] r_step;
    logic signed [VW-1:0] n_step;
    logic signed [VW-1:0] r_vel;
    logic signed [VW-1:0] n_vel;

    // Prediction datapath.
    logic signed [PW-1:0] h0_x;
    logic signed [PW-1:0] h1_x;
    logic signed [PW-1:0] h2_x;
    logic signed [PW-1:0] pred;
    logic signed [VW-1:0] pred_sat;
    logic                 pos_ovf;
    logic                 neg_ovf;
    logic                 use_pred;
    logic signed [VW-1:0] target;
    logic signed [VW-1:0] vel_eff;

    // Step datapath.
    logic signed [MW-1:0] diff;
    logic [MW-1:0]        mag;
    logic [XW-1:0]        prod;
    logic [MW-1:0]        quo;
    logic [VW-2:0]        step_mag;
    logic [VW-1:0]        step_ext;
    logic signed [VW-1:0] step_use;

    // Tick datapath.
    logic signed [MW-1:0] vsum;
    logic signed [MW-1:0] lo_x;
    logic signed [MW-1:0] hi_x;
    logic signed [MW-1:0] v_lo;
    logic signed [MW-1:0] v_hi;

    // Push the new sample into the history.
    always_comb begin
        n_hist = r_hist;
        unique case (i_ctl.count)
            2'd0: n_hist[0] = i_value;
            2'd1: n_hist[1] = i_value;
            2'd2: n_hist[2] = i_value;
            default: begin
                n_hist[0] = r_hist[1];
                n_hist[1] = r_hist[2];
                n_hist[2] = i_value;
            end
        endcase
    end

    // Quadratic extrapolation h0 - 3*h1 + 3*h2, saturated to the value range.
    assign h0_x = PW'(n_hist[0]);
    assign h1_x = PW'(n_hist[1]);
    assign h2_x = PW'(n_hist[2]);
    assign pred = h0_x - ((h1_x <<< 1) + h1_x) + ((h2_x <<< 1) + h2_x);

    assign pos_ovf = !pred[PW-1] && (pred[PW-2:VW-1] != '0);
    assign neg_ovf = pred[PW-1] && (pred[PW-2:VW-1] != '1);

    always_comb begin
        priority if (pos_ovf) begin
            pred_sat = {1'b0, {(VW-1){1'b1}}};
        end else if (neg_ovf) begin
            pred_sat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            pred_sat = pred[VW-1:0];
        end
    end

    // The prediction is used only with a full history and a matching strict sign.
    assign use_pred = (i_ctl.count >= 2'd2)
                   && (((pred_sat > 0) && (i_value > 0)) || ((pred_sat < 0) && (i_value < 0)));
    assign target   = use_pred ? pred_sat : i_value;

    // Signed difference to the velocity after any clear, split into sign and magnitude.
    assign vel_eff = i_ctl.clear ? '0 : r_vel;
    assign diff    = MW'(target) - MW'(vel_eff);
    assign mag     = diff[MW-1] ? -diff : diff;

    // Truncating division of the magnitude by the phase count through its reciprocal.
    assign prod = XW'(r_mag) * XW'(RECIP);
    assign quo  = prod[XW-1:SH];

    // Clamp the truncated quotient to the maximum step and restore the sign.
    assign step_mag = (quo > MW'(i_max_step)) ? i_max_step : quo[VW-2:0];
    assign step_ext = {1'b0, step_mag};
    assign n_step   = r_neg ? -step_ext : step_ext;

    // The cycle after a command uses the step that is just being finished.
    assign step_use = r_pend ? n_step : r_step;

    // Tick update: add the step, apply the floor first and the ceiling last.
    assign vsum  = MW'(r_vel) + MW'(step_use);
    assign lo_x  = MW'(i_lo);
    assign hi_x  = MW'(i_hi);
    assign v_lo  = (vsum < lo_x) ? lo_x : vsum;
    assign v_hi  = (v_lo > hi_x) ? hi_x : v_lo;
    assign n_vel = v_hi[VW-1:0];

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_vel  <= '0;
            r_step <= '0;
        end else begin
            r_pend <= i_ctl.cmd;
            if (i_ctl.cmd && i_ctl.clear) begin
                r_vel <= '0;
            end else if (i_ctl.tick) begin
                r_vel <= n_vel;
            end
            if (r_pend) begin
                r_step <= n_step;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd) begin
            r_hist <= n_hist;
            r_mag  <= mag;
            r_neg  <= diff[MW-1];
        end
    end

    assign o_vel_next = n_vel;

endmodule

[design/velocity_command_smoother_unit.sv]
// Channel    Direction  Handshake                       Contents
// s_axis     in         s_axis_tvalid / s_axis_tready   command or tick word
// m_axis     out        m_axis_tvalid / m_axis_tready   smoothed velocities
// apb        in         psel, penable, pwrite, pready   step, floor, ceiling, bound registers
//
// A command word is always accepted; a new word may follow every cycle unless a tick waits for output space.
// The command registers its target difference, and its step is finished in the next cycle,
// so a tick may directly follow a command.
// A tick is accepted when the output register is free or drains in the same cycle; when the history
// is not empty its word appears on m_axis the cycle after acceptance, so words can flow back to back.
// Reset is synchronous and active low; it empties the history and the output register.
module velocity_command_smoother_unit #(
    parameter int PHASE_STEPS = vcs_pkg::DEF_PHASE_STEPS,
    parameter int VALUE_WIDTH = vcs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // cmd_linear, cmd_angular, zero fill
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // op
    input  logic                                     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // out_linear, out_angular, zero fill
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [vcs_pkg::CFG_ADDR_W-1:0]           paddr,
    input  logic [vcs_pkg::CFG_DATA_W-1:0]           pwdata,
    output logic [vcs_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                     pready
);

`include "velocity_command_smoother_unit_macros.svh"

    localparam int VW      = VALUE_WIDTH;
    localparam int TDATA_W = ((2*VALUE_WIDTH+7)/8)*8;

    logic [VW-2:0]        lin_max_step;
    logic [VW-2:0]        ang_max_step;
    logic signed [VW-1:0] lin_floor;
    logic signed [VW-1:0] lin_ceiling;
    logic [VW-2:0]        ang_bound;
    logic signed [VW-1:0] ang_hi;
    logic signed [VW-1:0] ang_lo;

    logic signed [VW-1:0] cmd_lin;
    logic signed [VW-1:0] cmd_ang;
    logic                 in_acc;
    logic                 is_cmd;
    logic                 zero_cmd;
    logic                 out_space;
    logic signed [VW-1:0] lin_vel_next;
    logic signed [VW-1:0] ang_vel_next;

    vcs_pkg::t_hist_cnt   r_count;
    vcs_pkg::t_hist_cnt   cnt_eff;
    vcs_pkg::t_lane_ctl   lane_ctl;

    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_lin;
    logic signed [VW-1:0] r_out_ang;

    // Configuration registers.
    vcs_cfg #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_lin_max_step(lin_max_step),
        .o_ang_max_step(ang_max_step),
        .o_lin_floor   (lin_floor),
        .o_lin_ceiling (lin_ceiling),
        .o_ang_bound   (ang_bound)
    );

    assign ang_hi = {1'b0, ang_bound};
    assign ang_lo = -ang_hi;

    // Input word decode and handshake.
    assign cmd_lin   = s_axis_tdata[VW-1:0];
    assign cmd_ang   = s_axis_tdata[2*VW-1:VW];
    assign is_cmd    = (s_axis_tuser == vcs_pkg::OP_CMD);
    assign zero_cmd  = (cmd_lin == '0) && (cmd_ang == '0);
    assign out_space = !r_out_valid || m_axis_tready;

    assign s_axis_tready = is_cmd || out_space;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Shared history count and per-word lane control.
    assign cnt_eff = zero_cmd ? '0 : r_count;

    always_comb begin
        lane_ctl.cmd   = in_acc && is_cmd;
        lane_ctl.tick  = in_acc && !is_cmd && (r_count != '0);
        lane_ctl.clear = zero_cmd;
        lane_ctl.count = cnt_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (lane_ctl.cmd) begin
            r_count <= (cnt_eff == vcs_pkg::HIST_FULL) ? vcs_pkg::HIST_FULL : cnt_eff + 2'd1;
        end
    end

    // Linear and angular lanes.
    vcs_lane #(
        .PHASE_STEPS(PHASE_STEPS),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_lane_lin (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_value   (cmd_lin),
        .i_max_step(lin_max_step),
        .i_lo      (lin_floor),
        .i_hi      (lin_ceiling),
        .o_vel_next(lin_vel_next)
    );

    vcs_lane #(
        .PHASE_STEPS(PHASE_STEPS),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_lane_ang (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_value   (cmd_ang),
        .i_max_step(ang_max_step),
        .i_lo      (ang_lo),
        .i_hi      (ang_hi),
        .o_vel_next(ang_vel_next)
    );

    // Merge stage: both lanes' velocities land in one output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (lane_ctl.tick) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_ctl.tick) begin
            r_out_lin <= lin_vel_next;
            r_out_ang <= ang_vel_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'({r_out_ang, r_out_lin});

    // Checks on the input handshake and merge control.
    `VCS_ASSERT_NOW(a_cmd_always_ready, s_axis_tvalid && is_cmd, s_axis_tready, "command word refused")
    `VCS_ASSERT_NEXT(a_cmd_fills_history, lane_ctl.cmd, r_count != '0, "history empty after a command")
    `VCS_ASSERT_NEXT(a_tick_emits_word, lane_ctl.tick, r_out_valid, "tick with history produced no output word")

endmodule

[sim/tb_velocity_command_smoother_unit.sv]
`timescale 1ns / 1ps

module tb_velocity_command_smoother_unit;

    localparam int PHASE_STEPS = vcs_pkg::DEF_PHASE_STEPS;
    localparam int VALUE_WIDTH = vcs_pkg::DEF_VALUE_WIDTH;
    localparam longint VAL_MAX = 32767;
    localparam longint VAL_MIN = -32768;
    // A step may still be settling after the last command.
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic               op;
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } smoother_word_t;

    typedef struct packed {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } velocity_pair_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    // cmd_linear, cmd_angular
    logic [31:0] s_axis_tdata = '0;
    // op
    logic        s_axis_tuser = vcs_pkg::OP_CMD;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_linear, out_angular
    wire  [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    velocity_command_smoother_unit #(
        .PHASE_STEPS(PHASE_STEPS),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // Words waiting to be sent and velocities waiting to come out.
    smoother_word_t input_words[$];
    velocity_pair_t pending_velocities[$];
    int             mismatch_count = 0;
    logic           word_taken = 1'b0;

    // Register copies used for prediction.
    longint lin_step_limit = longint'(vcs_pkg::RST_LIN_MAX_STEP);
    longint ang_step_limit = longint'(vcs_pkg::RST_ANG_MAX_STEP);
    longint lin_floor_q    = longint'(vcs_pkg::RST_LIN_FLOOR);
    longint lin_ceiling_q  = longint'(vcs_pkg::RST_LIN_CEILING);
    longint ang_bound_q    = longint'(vcs_pkg::RST_ANG_BOUND);

    // Smoother state used for prediction.
    longint lin_hist[3];
    longint ang_hist[3];
    int     hist_fill = 0;
    longint lin_step_q = 0;
    longint ang_step_q = 0;
    longint lin_vel = 0;
    longint ang_vel = 0;

    function automatic longint clamp_value(longint v, longint lo, longint hi);
        longint r;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    // Per-tick step toward the newest sample or its quadratic extrapolation.
    function automatic longint step_toward(longint h0, longint h1, longint h2, int n,
                                           longint vel, longint max_step);
        longint newest;
        longint target;
        longint pred;
        newest = (n == 1) ? h0 : ((n == 2) ? h1 : h2);
        target = newest;
        if (n == 3) begin
            pred = clamp_value(h0 - 3 * h1 + 3 * h2, VAL_MIN, VAL_MAX);
            if ((pred > 0 && newest > 0) || (pred < 0 && newest < 0))
                target = pred;
        end
        return clamp_value((target - vel) / PHASE_STEPS, -max_step, max_step);
    endfunction

    // Advances the smoother by one word and reports the velocity pair it emits.
    task automatic advance_smoother(input logic op, input logic signed [15:0] lin_in,
                                    input logic signed [15:0] ang_in,
                                    output bit emitted, output velocity_pair_t result);
        longint cl;
        longint ca;
        emitted = 1'b0;
        result = '0;
        cl = longint'(lin_in);
        ca = longint'(ang_in);
        if (op == vcs_pkg::OP_CMD) begin
            // A zero command on both axes restarts the history.
            if (cl == 0 && ca == 0) begin
                hist_fill = 0;
                lin_vel = 0;
                ang_vel = 0;
            end
            if (hist_fill < 3) begin
                lin_hist[hist_fill] = cl;
                ang_hist[hist_fill] = ca;
                hist_fill++;
            end else begin
                lin_hist[0] = lin_hist[1];
                lin_hist[1] = lin_hist[2];
                lin_hist[2] = cl;
                ang_hist[0] = ang_hist[1];
                ang_hist[1] = ang_hist[2];
                ang_hist[2] = ca;
            end
            lin_step_q = step_toward(lin_hist[0], lin_hist[1], lin_hist[2], hist_fill,
                                     lin_vel, lin_step_limit);
            ang_step_q = step_toward(ang_hist[0], ang_hist[1], ang_hist[2], hist_fill,
                                     ang_vel, ang_step_limit);
        end else if (hist_fill != 0) begin
            // Floor first, then ceiling, so the ceiling wins when they cross.
            lin_vel = clamp_value(lin_vel + lin_step_q, lin_floor_q, lin_ceiling_q);
            ang_vel = clamp_value(ang_vel + ang_step_q, -ang_bound_q, ang_bound_q);
            emitted = 1'b1;
            result.lin = lin_vel[15:0];
            result.ang = ang_vel[15:0];
        end
    endtask

    // Check each output word against the oldest expectation, then predict
    // for each accepted input word.
    always @(posedge i_clk) begin : check_and_predict
        velocity_pair_t oldest;
        velocity_pair_t fresh;
        bit             emitted;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_velocities.size() == 0) begin
                    $display("%0t: output word with none expected, linear %0d angular %0d",
                             $time, $signed(m_axis_tdata[15:0]),
                             $signed(m_axis_tdata[31:16]));
                    mismatch_count++;
                end else begin
                    oldest = pending_velocities.pop_front();
                    if (m_axis_tdata[15:0] !== oldest.lin) begin
                        $display("%0t: out_linear expected %0d actual %0d", $time,
                                 oldest.lin, $signed(m_axis_tdata[15:0]));
                        mismatch_count++;
                    end
                    if (m_axis_tdata[31:16] !== oldest.ang) begin
                        $display("%0t: out_angular expected %0d actual %0d", $time,
                                 oldest.ang, $signed(m_axis_tdata[31:16]));
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                word_taken = 1'b1;
                advance_smoother(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                                 emitted, fresh);
                if (emitted)
                    pending_velocities.push_back(fresh);
            end
        end
    end

    // Sender: bursts of words from the queue with random gaps between them.
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin : drive_words
        smoother_word_t w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !word_taken) begin
            // Hold the word until it is taken.
        end else if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (input_words.size() > 0) begin
            w = input_words.pop_front();
            s_axis_tuser <= w.op;
            s_axis_tdata <= {w.ang, w.lin};
            s_axis_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: stall pattern that switches between regimes of random length.
    int stall_mode = 0;
    int stall_left = 0;

    always @(negedge i_clk) begin : drive_ready
        logic ready_next;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = ($urandom_range(0, 7) != 0);
        endcase
        m_axis_tready <= ready_next;
    end

    function automatic logic signed [15:0] pick_velocity();
        logic signed [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: begin
                v = 16'($urandom_range(0, 8190));
                v = v - 16'sd4095;
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = 16'sd0;
                    3: v = 16'sd1;
                    default: v = -16'sd1;
                endcase
            end
            default: begin
                v = 16'($urandom_range(0, 400));
                v = v - 16'sd200;
            end
        endcase
        return v;
    endfunction

    task automatic push_word(input logic op, input logic signed [15:0] lin,
                             input logic signed [15:0] ang);
        smoother_word_t w;
        w.op = op;
        w.lin = lin;
        w.ang = ang;
        input_words.push_back(w);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_word(vcs_pkg::OP_TICK, 16'($urandom), 16'($urandom));
    endtask

    // Mostly a command followed by its ticks, some command runs, a few zero
    // commands and loose words.
    task automatic queue_random_words(input int count);
        int made;
        int kind;
        int n;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                push_word(vcs_pkg::OP_CMD, pick_velocity(), pick_velocity());
                n = $urandom_range(1, 8);
                push_ticks(n);
                made += n + 1;
            end else if (kind < 16) begin
                n = $urandom_range(2, 4);
                repeat (n) push_word(vcs_pkg::OP_CMD, pick_velocity(), pick_velocity());
                made += n;
                n = $urandom_range(2, 7);
                push_ticks(n);
                made += n;
            end else if (kind < 17) begin
                push_word(vcs_pkg::OP_CMD, 16'sd0, 16'sd0);
                n = $urandom_range(1, 4);
                push_ticks(n);
                made += n + 1;
            end else begin
                push_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                made++;
            end
        end
    endtask

    // Register write over the configuration port; the copy follows it.
    task automatic write_register(input logic [2:0] idx, input longint value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            vcs_pkg::REG_LIN_MAX_STEP: lin_step_limit = value & 32'h7FFF;
            vcs_pkg::REG_ANG_MAX_STEP: ang_step_limit = value & 32'h7FFF;
            vcs_pkg::REG_LIN_FLOOR:    lin_floor_q = $signed(value[15:0]);
            vcs_pkg::REG_LIN_CEILING:  lin_ceiling_q = $signed(value[15:0]);
            vcs_pkg::REG_ANG_BOUND:    ang_bound_q = value & 32'h7FFF;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input longint lin_max, input longint ang_max,
                                  input longint floor_v, input longint ceiling_v,
                                  input longint bound);
        write_register(vcs_pkg::REG_LIN_MAX_STEP, lin_max);
        write_register(vcs_pkg::REG_ANG_MAX_STEP, ang_max);
        write_register(vcs_pkg::REG_LIN_FLOOR, floor_v);
        write_register(vcs_pkg::REG_LIN_CEILING, ceiling_v);
        write_register(vcs_pkg::REG_ANG_BOUND, bound);
    endtask

    // Waits until every word is sent and every velocity has come out,
    // then lets the last step settle.
    task automatic wait_idle();
        while (input_words.size() != 0 || s_axis_tvalid || pending_velocities.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Tick before any command, extremes with saturated extrapolation,
        // zero newest sample, zero command, sign disagreement.
        push_ticks(1);
        push_word(vcs_pkg::OP_CMD, 16'sh7FFF, 16'sh8000);
        push_ticks(2);
        push_word(vcs_pkg::OP_CMD, 16'sh7FFF, 16'sh8000);
        push_word(vcs_pkg::OP_CMD, 16'sh8000, 16'sh7FFF);
        push_ticks(3);
        push_word(vcs_pkg::OP_CMD, 16'sd0, 16'sd1000);
        push_ticks(1);
        push_word(vcs_pkg::OP_CMD, 16'sd0, 16'sd0);
        push_ticks(2);
        push_word(vcs_pkg::OP_CMD, 16'sd100, -16'sd100);
        push_word(vcs_pkg::OP_CMD, 16'sd200, -16'sd200);
        push_word(vcs_pkg::OP_CMD, 16'sd300, -16'sd300);
        push_word(vcs_pkg::OP_CMD, -16'sd50, 16'sd50);
        push_ticks(3);
        wait_idle();

        // Reset settings.
        queue_random_words(200);
        wait_idle();

        // Everything wide open.
        apply_settings(32767, 32767, -32768, 32767, 32767);
        queue_random_words(200);
        wait_idle();

        // Zero steps and bound, floor above ceiling at the extremes.
        apply_settings(0, 0, 32767, -32768, 0);
        queue_random_words(100);
        wait_idle();

        // Floor above ceiling with moderate steps.
        apply_settings(200, 300, 1000, -1000, 100);
        queue_random_words(150);
        wait_idle();

        // Random settings.
        repeat (4) begin
            apply_settings($urandom_range(0, 32767) >> $urandom_range(0, 12),
                           $urandom_range(0, 32767) >> $urandom_range(0, 12),
                           pick_velocity(), pick_velocity(),
                           $urandom_range(0, 32767) >> $urandom_range(0, 4));
            queue_random_words(100);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_velocities.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
